### sv/lzwpd_pkg.sv
// Shared types and constants for the LZW picture decoder.
// No dependencies.
package lzwpd_pkg;

  localparam int DICT_ENTRIES_DEF      = 3840;
  localparam int SEQ_MAX_DEF           = 512;
  localparam int PIXELS_PER_RESULT_DEF = 8;
  localparam int MAX_RESULTS           = 64;

  localparam logic [11:0] CODE_CLEAR = 12'd256;
  localparam logic [11:0] CODE_END   = 12'd257;
  localparam logic [12:0] ENTRY_INIT = 13'd257;
  localparam logic [3:0]  WIDTH_MIN  = 4'd9;
  localparam logic [3:0]  WIDTH_MAX  = 4'd12;
  localparam logic [7:0]  MAP_LOW    = 8'd224;
  localparam logic [7:0]  MAP_HIGH   = 8'd225;
  localparam logic [7:0]  MAP_KEY    = 8'd2;

  localparam logic [1:0] REG_PIXEL_MODE   = 2'd0;
  localparam logic [1:0] REG_TRANS_ENABLE = 2'd1;
  localparam logic [1:0] REG_TRANS_INDEX  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_EMIT,
    S_ENDP
  } lzwpd_state_t;

endpackage

### sv/lzw_picture_decoder.sv
// LZW picture decoder top level: bit unpacker, dictionary chain walker, pixel packer.
// Depends on lzwpd_pkg.
// A byte that completes no code, and a code that completes no sequence, is handled in S_IDLE.
// A data code is accepted, walked down its dictionary chain (one dictionary read per step,
// into the sequence buffer) and packed into pixels, one byte a cycle unless the output stalls.
// The end code passes through S_ENDP. One item at a time. Reset (rst_n low, synchronous)
// clears the control state; the dictionary is undefined until written.
module lzw_picture_decoder
  import lzwpd_pkg::*;
#(
  parameter int DICT_ENTRIES      = DICT_ENTRIES_DEF,
  parameter int SEQ_MAX           = SEQ_MAX_DEF,
  parameter int PIXELS_PER_RESULT = PIXELS_PER_RESULT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_compressed_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_pixels,
  output logic [7:0]  out_transparent_mask,
  output logic [3:0]  out_pixel_count,
  output logic        out_last_of_code,
  output logic        out_picture_end
);

  localparam int SEQ_CAP = (SEQ_MAX < MAX_RESULTS * PIXELS_PER_RESULT) ?
                           SEQ_MAX : MAX_RESULTS * PIXELS_PER_RESULT;
  localparam int IW  = $clog2(SEQ_CAP);
  localparam int DW  = $clog2(DICT_ENTRIES);
  localparam int PCW = (PIXELS_PER_RESULT > 1) ? $clog2(PIXELS_PER_RESULT) : 1;
  localparam int PW  = 8 * PIXELS_PER_RESULT;
  localparam logic [12:0] DICT_END = 13'(256 + DICT_ENTRIES);

  // configuration
  logic       mode_r, ten_r;
  logic [3:0] tidx_r;

  // stream state
  logic [11:0] bb_r, bb_nxt;
  logic [3:0]  bh_r, bh_nxt;
  logic [3:0]  cw_r, cw_nxt;
  logic [12:0] ne_r, ne_nxt;
  logic [11:0] prev_r, prev_nxt;

  lzwpd_state_t state_r, state_nxt;
  logic [11:0] code_r, code_nxt;
  logic [11:0] val_r, val_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] top_r, top_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic        kwk_r, kwk_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [PCW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0]  pix_r, pix_nxt;
  logic [PIXELS_PER_RESULT-1:0] msk_r, msk_nxt;

  // output register
  logic        ov_r, ov_nxt;
  logic [63:0] opix_r, opix_nxt;
  logic [7:0]  omsk_r, omsk_nxt;
  logic [3:0]  ocnt_r, ocnt_nxt;
  logic        olast_r, olast_nxt;
  logic        oend_r, oend_nxt;

  // memories
  logic [7:0]  suf_mem [DICT_ENTRIES];
  logic [11:0] pre_mem [DICT_ENTRIES];
  logic [7:0]  rb_mem  [SEQ_CAP];
  logic [7:0]  suf_q;
  logic [11:0] pre_q;
  logic        inrng_r;
  logic [7:0]  rb_q;

  logic [11:0] rd_val;
  logic        rd_inrng;
  logic [DW-1:0] rd_idx, wr_idx;
  logic        dict_we, rb_we;
  logic [7:0]  rb_wdata;

  // combinational temporaries
  logic [19:0] acc, accs;
  logic [4:0]  held;
  logic [11:0] code;
  logic [7:0]  suf_eff, byte_v, pix_v;
  logic [11:0] pre_eff;
  logic        slot_free, trans_v, fin;
  logic [3:0]  cw_g;

  assign in_ready  = (state_r == S_IDLE);
  assign slot_free = !ov_r || out_ready;
  assign suf_eff   = inrng_r ? suf_q : 8'd0;
  assign pre_eff   = inrng_r ? pre_q : 12'd0;
  assign rd_inrng  = (rd_val >= 12'd256) && ({1'b0, rd_val} < DICT_END);
  assign rd_idx    = DW'(rd_val - 12'd256);
  assign wr_idx    = DW'(ne_r - 13'd256);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      ten_r  <= 1'b0;
      tidx_r <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PIXEL_MODE:   mode_r <= cfg_data[0];
        REG_TRANS_ENABLE: ten_r  <= cfg_data[0];
        REG_TRANS_INDEX:  tidx_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    suf_q   <= suf_mem[rd_idx];
    pre_q   <= pre_mem[rd_idx];
    inrng_r <= rd_inrng;
    if (dict_we) begin
      suf_mem[wr_idx] <= first_nxt;
      pre_mem[wr_idx] <= prev_r;
    end
  end

  always_ff @(posedge clk) begin
    rb_q <= rb_mem[idx_nxt];
    if (rb_we) rb_mem[i_r] <= rb_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      bb_r    <= 12'd0;
      bh_r    <= 4'd0;
      cw_r    <= WIDTH_MIN;
      ne_r    <= ENTRY_INIT;
      prev_r  <= 12'd0;
      ov_r    <= 1'b0;
      cnt_r   <= '0;
      pix_r   <= '0;
      msk_r   <= '0;
    end else begin
      state_r <= state_nxt;
      bb_r    <= bb_nxt;
      bh_r    <= bh_nxt;
      cw_r    <= cw_nxt;
      ne_r    <= ne_nxt;
      prev_r  <= prev_nxt;
      ov_r    <= ov_nxt;
      cnt_r   <= cnt_nxt;
      pix_r   <= pix_nxt;
      msk_r   <= msk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r  <= code_nxt;
    val_r   <= val_nxt;
    i_r     <= i_nxt;
    top_r   <= top_nxt;
    idx_r   <= idx_nxt;
    kwk_r   <= kwk_nxt;
    first_r <= first_nxt;
    opix_r  <= opix_nxt;
    omsk_r  <= omsk_nxt;
    ocnt_r  <= ocnt_nxt;
    olast_r <= olast_nxt;
    oend_r  <= oend_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    bb_nxt    = bb_r;
    bh_nxt    = bh_r;
    cw_nxt    = cw_r;
    ne_nxt    = ne_r;
    prev_nxt  = prev_r;
    code_nxt  = code_r;
    val_nxt   = val_r;
    i_nxt     = i_r;
    top_nxt   = top_r;
    idx_nxt   = idx_r;
    kwk_nxt   = kwk_r;
    first_nxt = first_r;
    cnt_nxt   = cnt_r;
    pix_nxt   = pix_r;
    msk_nxt   = msk_r;
    ov_nxt    = ov_r && !out_ready;
    opix_nxt  = opix_r;
    omsk_nxt  = omsk_r;
    ocnt_nxt  = ocnt_r;
    olast_nxt = olast_r;
    oend_nxt  = oend_r;
    rd_val    = val_r;
    dict_we   = 1'b0;
    rb_we     = 1'b0;
    rb_wdata  = suf_eff;
    acc       = 20'(bb_r) | (20'(in_compressed_byte) << bh_r);
    held      = 5'(bh_r) + 5'd8;
    code      = acc[11:0] & (12'hfff >> (4'd12 - cw_r));
    accs      = acc >> cw_r;
    byte_v    = rb_q;
    pix_v     = 8'd0;
    trans_v   = 1'b0;
    fin       = 1'b0;
    cw_g      = cw_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (held < 5'(cw_r)) begin
            bb_nxt = acc[11:0];
            bh_nxt = held[3:0];
          end else begin
            bb_nxt = accs[11:0];
            bh_nxt = 4'(held - 5'(cw_r));
            if (code == CODE_CLEAR) begin
              cw_nxt = WIDTH_MIN;
              ne_nxt = ENTRY_INIT;
            end else if (code == CODE_END) begin
              bb_nxt    = 12'd0;
              bh_nxt    = 4'd0;
              state_nxt = S_ENDP;
            end else begin
              code_nxt = code;
              kwk_nxt  = ({1'b0, code} == ne_r);
              val_nxt  = kwk_nxt ? prev_r : code;
              i_nxt    = kwk_nxt ? IW'(1) : '0;
              rd_val   = val_nxt;
              state_nxt = S_WALK;
            end
          end
        end
      end

      S_WALK: begin
        if ((val_r[11:8] != 4'd0) && (i_r < IW'(SEQ_CAP - 1))) begin
          rb_we   = 1'b1;
          i_nxt   = i_r + IW'(1);
          val_nxt = pre_eff;
          rd_val  = pre_eff;
        end else begin
          // first byte of the sequence; kept in a register, not the buffer
          first_nxt = val_r[7:0];
          top_nxt   = i_r;
          idx_nxt   = i_r;
          prev_nxt  = code_r;
          if (ne_r < DICT_END) begin
            dict_we = 1'b1;
            ne_nxt  = ne_r + 13'd1;
            if ((ne_nxt == (13'd1 << cw_r)) && (cw_r < WIDTH_MAX)) cw_g = cw_r + 4'd1;
            cw_nxt = cw_g;
          end
          cnt_nxt   = '0;
          pix_nxt   = '0;
          msk_nxt   = '0;
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if ((idx_r == top_r) || ((idx_r == '0) && kwk_r)) byte_v = first_r;
        else byte_v = rb_q;
        pix_v   = mode_r ? ((byte_v == MAP_KEY) ? MAP_LOW : MAP_HIGH) : byte_v;
        trans_v = ten_r && (byte_v == {4'd0, tidx_r});
        if (trans_v) pix_v = 8'd0;
        fin = (idx_r == '0) || (cnt_r == PCW'(PIXELS_PER_RESULT - 1));
        if (!fin || slot_free) begin
          pix_nxt[cnt_r*8 +: 8] = pix_v;
          msk_nxt[cnt_r]        = trans_v;
          cnt_nxt               = cnt_r + PCW'(1);
          if (idx_r != '0) idx_nxt = idx_r - IW'(1);
          if (fin) begin
            ov_nxt    = 1'b1;
            opix_nxt  = 64'(pix_nxt);
            omsk_nxt  = 8'(msk_nxt);
            ocnt_nxt  = 4'(cnt_r) + 4'd1;
            olast_nxt = (idx_r == '0);
            oend_nxt  = 1'b0;
            cnt_nxt   = '0;
            pix_nxt   = '0;
            msk_nxt   = '0;
            if (idx_r == '0) state_nxt = S_IDLE;
          end
        end
      end

      S_ENDP: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          opix_nxt  = 64'd0;
          omsk_nxt  = 8'd0;
          ocnt_nxt  = 4'd0;
          olast_nxt = 1'b1;
          oend_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid            = ov_r;
  assign out_pixels           = opix_r;
  assign out_transparent_mask = omsk_r;
  assign out_pixel_count      = ocnt_r;
  assign out_last_of_code     = olast_r;
  assign out_picture_end      = oend_r;

endmodule

### sv/lzwpd_checker.sv
// Port-level checks for the LZW picture decoder, bound to the top level.
// Depends on lzwpd_pkg and lzw_picture_decoder.
module lzwpd_checker
  import lzwpd_pkg::*;
#(
  parameter int PIXELS_PER_RESULT = PIXELS_PER_RESULT_DEF
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_pixels,
  input logic [7:0]  out_transparent_mask,
  input logic [3:0]  out_pixel_count,
  input logic        out_last_of_code,
  input logic        out_picture_end
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixels) && $stable(out_pixel_count))
    else $error("result changed while stalled");

  a_end_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_picture_end |-> out_last_of_code && out_pixel_count == 4'd0 &&
      out_pixels == 64'd0 && out_transparent_mask == 8'd0)
    else $error("bad end result");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_picture_end |-> out_pixel_count != 4'd0 &&
      out_pixel_count <= 4'(PIXELS_PER_RESULT))
    else $error("bad pixel count");

  // a non-final result is always full
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_code |-> out_pixel_count == 4'(PIXELS_PER_RESULT))
    else $error("partial result before last");

  // mask bits above the pixel count stay clear
  a_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pixel_count < 4'd8 |->
      (out_transparent_mask >> out_pixel_count) == 8'd0)
    else $error("mask bit beyond count");

endmodule

bind lzw_picture_decoder lzwpd_checker #(
  .PIXELS_PER_RESULT(PIXELS_PER_RESULT)
) u_lzwpd_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_pixels           (out_pixels),
  .out_transparent_mask (out_transparent_mask),
  .out_pixel_count      (out_pixel_count),
  .out_last_of_code     (out_last_of_code),
  .out_picture_end      (out_picture_end)
);

### dv/lzw_picture_decoder_tb.sv
// Self-checking testbench for lzw_picture_decoder: builds legal LZW code streams,
// predicts every pixel result and compares it against the DUT output channel.
// Depends on lzwpd_pkg and lzw_picture_decoder.
`timescale 1ns / 1ps

module lzw_picture_decoder_tb;
  import lzwpd_pkg::*;

  localparam int DICT_SIZE   = DICT_ENTRIES_DEF;
  localparam int SEQ_LIMIT   = SEQ_MAX_DEF;
  localparam int IDLE_LIMIT  = 20000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [63:0] pixels;
    logic [7:0]  mask;
    logic [3:0]  count;
    logic        last;
    logic        pic_end;
  } pix_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_compressed_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_pixels;
  logic [7:0]  out_transparent_mask;
  logic [3:0]  out_pixel_count;
  logic        out_last_of_code;
  logic        out_picture_end;

  lzw_picture_decoder u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_compressed_byte   (in_compressed_byte),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_pixels           (out_pixels),
    .out_transparent_mask (out_transparent_mask),
    .out_pixel_count      (out_pixel_count),
    .out_last_of_code     (out_last_of_code),
    .out_picture_end      (out_picture_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // stimulus and scoreboard storage
  logic [7:0]  byte_q[$];
  pix_result_t pixel_q[$];
  int          fail_count = 0;
  int          bytes_sent = 0;
  int          results_seen = 0;
  int          ends_seen = 0;
  bit          gaps_on = 1'b0;
  bit          hold_req = 1'b0;

  // predictor state
  logic        two_level;
  logic        trans_en;
  logic [3:0]  trans_idx;
  logic [11:0] bitbuf;
  logic [3:0]  nbits;
  logic [3:0]  width;
  logic [12:0] next_code;
  logic [11:0] last_code;
  logic [7:0]  dict_suffix[DICT_SIZE];
  logic [11:0] dict_prefix[DICT_SIZE];
  logic [7:0]  seq_buf[SEQ_LIMIT];

  // encoder-side state used to build legal streams
  logic [31:0] enc_acc;
  int          enc_bits;
  int          enc_width;
  int          enc_next;

  function automatic logic [7:0] suffix_at(input logic [11:0] code);
    if (code >= 12'd256 && int'(code) - 256 < DICT_SIZE) return dict_suffix[code - 12'd256];
    return 8'd0;
  endfunction

  function automatic logic [11:0] prefix_at(input logic [11:0] code);
    if (code >= 12'd256 && int'(code) - 256 < DICT_SIZE) return dict_prefix[code - 12'd256];
    return 12'd0;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    logic [19:0] acc;
    int          held;
    logic [11:0] code;
    logic [11:0] val;
    int          i;
    int          len;
    int          n;
    int          cnt;
    logic [7:0]  d;
    logic [7:0]  p;
    pix_result_t r;
    acc  = {8'd0, bitbuf} | (20'(b) << nbits);
    held = int'(nbits) + 8;
    if (held < int'(width)) begin
      bitbuf = acc[11:0];
      nbits  = 4'(held);
      return;
    end
    code   = acc[11:0] & (12'hfff >> (12 - width));
    acc    = acc >> width;
    held   = held - int'(width);
    bitbuf = acc[11:0];
    nbits  = 4'(held);
    if (code == CODE_CLEAR) begin
      width     = WIDTH_MIN;
      next_code = ENTRY_INIT;
      return;
    end
    if (code == CODE_END) begin
      bitbuf = '0;
      nbits  = '0;
      r = '{pixels: '0, mask: '0, count: '0, last: 1'b1, pic_end: 1'b1};
      pixel_q.push_back(r);
      return;
    end
    val = code;
    i = 0;
    if ({1'b0, code} == next_code) begin
      val = last_code;
      i = 1;
    end
    while (val > 12'd255 && i < SEQ_LIMIT - 1) begin
      seq_buf[i] = suffix_at(val);
      i++;
      val = prefix_at(val);
    end
    val = val & 12'hff;
    seq_buf[i] = val[7:0];
    if ({1'b0, code} == next_code) seq_buf[0] = val[7:0];
    len = i + 1;
    if (int'(next_code) < 256 + DICT_SIZE) begin
      dict_suffix[next_code - 13'd256] = val[7:0];
      dict_prefix[next_code - 13'd256] = last_code;
      next_code++;
      if (next_code == (13'd1 << width) && width < WIDTH_MAX) width++;
    end
    last_code = code;
    n = 0;
    while (n < len) begin
      r = '0;
      cnt = 0;
      while (cnt < PIXELS_PER_RESULT_DEF && n < len) begin
        d = seq_buf[len - 1 - n];
        p = d;
        if (two_level) p = (d == MAP_KEY) ? MAP_LOW : MAP_HIGH;
        if (trans_en && d == {4'd0, trans_idx}) begin
          p = 8'd0;
          r.mask[cnt] = 1'b1;
        end
        r.pixels[8*cnt +: 8] = p;
        cnt++;
        n++;
      end
      r.count = 4'(cnt);
      r.last  = (n == len);
      pixel_q.push_back(r);
    end
  endtask

  // pack one code LSB first into the byte stream, tracking the table as the DUT grows it
  task automatic put_code(input int code);
    enc_acc  = enc_acc | (32'(code) << enc_bits);
    enc_bits = enc_bits + enc_width;
    while (enc_bits >= 8) begin
      byte_q.push_back(enc_acc[7:0]);
      enc_acc  = enc_acc >> 8;
      enc_bits = enc_bits - 8;
    end
    if (code == int'(CODE_CLEAR)) begin
      enc_width = 9;
      enc_next  = 257;
    end else if (code == int'(CODE_END)) begin
      // the rest of the byte holding the end code is dropped by the DUT
      if (enc_bits > 0) byte_q.push_back(enc_acc[7:0] | (8'($urandom) << enc_bits));
      enc_acc  = '0;
      enc_bits = 0;
    end else if (enc_next < 256 + DICT_SIZE) begin
      enc_next++;
      if (enc_next == (1 << enc_width) && enc_width < 12) enc_width++;
    end
  endtask

  function automatic bit kwk_ok();
    return enc_next != 257 && enc_next < (1 << enc_width);
  endfunction

  task automatic put_random_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) put_code(CODE_CLEAR);
    else if (r < 7) put_code(CODE_END);
    else if (r < 45 || enc_next <= 258) put_code($urandom_range(0, 255));
    else if (r < 60 && kwk_ok()) put_code(enc_next);
    else put_code($urandom_range(258, enc_next - 1));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PIXEL_MODE:   two_level = data[0];
      REG_TRANS_ENABLE: trans_en  = data[0];
      REG_TRANS_INDEX:  trans_idx = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic mode, input logic en, input logic [3:0] idx);
    write_reg(REG_PIXEL_MODE, {3'd0, mode});
    write_reg(REG_TRANS_ENABLE, {3'd0, en});
    write_reg(REG_TRANS_INDEX, idx);
  endtask

  task automatic wait_drain();
    do @(posedge clk);
    while (byte_q.size() != 0 || in_valid || pixel_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic report(input string what);
    $display("ERROR %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        decode_byte(in_compressed_byte);
        bytes_sent++;
      end
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        in_valid <= 1'b1;
        in_compressed_byte <= byte_q.pop_front();
        in_gap <= gaps_on ? $urandom_range(0, 5) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver back-pressure
  int  out_wait = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin
    pix_result_t got;
    pix_result_t want;
    int          n;
    if (rst_n && out_valid && out_ready) begin
      got = '{pixels: out_pixels, mask: out_transparent_mask, count: out_pixel_count,
              last: out_last_of_code, pic_end: out_picture_end};
      results_seen++;
      if (out_picture_end) ends_seen++;
      if (pixel_q.size() == 0) begin
        report("result transfer with nothing expected");
      end else begin
        want = pixel_q.pop_front();
        if (got.pixels !== want.pixels)
          report($sformatf("pixels %h, expected %h", got.pixels, want.pixels));
        if (got.mask !== want.mask)
          report($sformatf("transparent_mask %h, expected %h", got.mask, want.mask));
        if (got.count !== want.count)
          report($sformatf("pixel_count %0d, expected %0d", got.count, want.count));
        if (got.last !== want.last)
          report($sformatf("last_of_code %b, expected %b", got.last, want.last));
        if (got.pic_end !== want.pic_end)
          report($sformatf("picture_end %b, expected %b", got.pic_end, want.pic_end));
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= (hold_left == 1);
    end else if (out_valid && out_ready) begin
      n = gaps_on ? $urandom_range(0, 5) : 0;
      out_wait  <= n;
      out_ready <= (n == 0);
    end else if (out_wait > 0) begin
      out_wait  <= out_wait - 1;
      out_ready <= (out_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog: cycles without any transfer
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int start;
    two_level = 1'b0;
    trans_en  = 1'b0;
    trans_idx = '0;
    bitbuf    = '0;
    nbits     = '0;
    width     = WIDTH_MIN;
    next_code = ENTRY_INIT;
    last_code = '0;
    enc_acc   = '0;
    enc_bits  = 0;
    enc_width = 9;
    enc_next  = 257;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, repeat-previous code, clear, end
    set_config(1'b0, 1'b1, 4'd0);
    gaps_on = 1'b1;
    put_code(0);
    put_code(255);
    put_code(enc_next);
    put_code(2);
    put_code(15);
    put_code(258);
    put_code(CODE_CLEAR);
    put_code(7);
    put_code(enc_next);
    put_code(enc_next);
    put_code(CODE_END);
    put_code(1);
    put_code(259);
    put_code(CODE_END);
    wait_drain();

    // random phases over the register extremes
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_config(1'b1, 1'b1, 4'd15);
        1: set_config(1'b0, 1'b0, 4'd15);
        2: set_config(1'b1, 1'b0, 4'd2);
        default: set_config(1'b0, 1'b1, 4'd2);
      endcase
      gaps_on = (ph != 2);
      if (ph == 1) hold_req = 1'b1;
      start = bytes_sent + byte_q.size();
      while (bytes_sent + byte_q.size() - start < 100) put_random_code();
      wait_drain();
    end

    // a long chain of repeat-previous codes, then end and clear
    set_config(1'b1, 1'b1, 4'd1);
    gaps_on = 1'b0;
    put_code(CODE_CLEAR);
    put_code($urandom_range(0, 255));
    for (int k = 0; k < 30; k++) put_code(enc_next);
    put_code(CODE_END);
    put_code(CODE_CLEAR);
    put_code(3);
    wait_drain();

    $display("covered %0d compressed bytes, %0d pixel results, %0d picture ends",
             bytes_sent, results_seen, ends_seen);
    $display("stream ran through clear, end, repeat-previous codes and a long chain");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
